// File: rtl/core/aoa_tdoa_measurement_predictor_defines.svh
// Assertion macros shared by the measurement predictor RTL.
`ifndef AOA_TDOA_MEASUREMENT_PREDICTOR_DEFINES_SVH
`define AOA_TDOA_MEASUREMENT_PREDICTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define AOATP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define AOATP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define AOATP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AOATP_ASSERT_ALWAYS(lbl, cond, msg)
`define AOATP_ASSERT_IMPL(lbl, ante, cons, msg)
`define AOATP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/aoatp_pkg.sv
// Types, constants and helper functions of the measurement predictor.
package aoatp_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int CORDIC_W        = 36;
  localparam int ANGLE_W         = 24;
  localparam int CORDIC_STEPS    = 17;
  localparam int ROOT_W          = 24;
  localparam int REM_W           = 28;
  localparam int RAD_W           = 48;
  localparam int STEPS_PER_STAGE = 3;
  localparam int CORE_STAGES     = 8;
  localparam int PRESCALE_SHIFT  = 7;

  localparam logic signed [31:0] NEAR_LIMIT = 32'sd1966080;
  localparam logic signed [ANGLE_W-1:0] PI_Q = 24'sd205887;
  localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

  typedef enum logic [2:0] {
    REG_ANGLE_SEL  = 3'd0,
    REG_PAIR_SEL   = 3'd1,
    REG_ANGLE_CNT  = 3'd2,
    REG_TIME_STEP  = 3'd3,
    REG_RANGE_SCL  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [ANGLE_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  function automatic logic signed [31:0] sat_word(input logic signed [63:0] v);
    if (v > WORD_MAX) return 32'sh7FFFFFFF;
    if (v < WORD_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sensor_x(input logic [1:0] k);
    case (k)
      2'd0:    return 32'sd0;
      2'd1:    return -32'sd128195;
      2'd2:    return -32'sd25105256;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sensor_y(input logic [1:0] k);
    case (k)
      2'd0:    return 32'sd0;
      2'd1:    return -32'sd48484149;
      2'd2:    return -32'sd151178;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic logic signed [ANGLE_W-1:0] atan_step(input logic [4:0] i);
    case (i)
      5'd0:    return 24'sd51472;
      5'd1:    return 24'sd30386;
      5'd2:    return 24'sd16055;
      5'd3:    return 24'sd8150;
      5'd4:    return 24'sd4091;
      5'd5:    return 24'sd2047;
      5'd6:    return 24'sd1024;
      5'd7:    return 24'sd512;
      5'd8:    return 24'sd256;
      5'd9:    return 24'sd128;
      5'd10:   return 24'sd64;
      5'd11:   return 24'sd32;
      5'd12:   return 24'sd16;
      5'd13:   return 24'sd8;
      5'd14:   return 24'sd4;
      5'd15:   return 24'sd2;
      5'd16:   return 24'sd1;
      default: return 24'sd0;
    endcase
  endfunction

  // One vectoring rotation: drive y toward zero and track the angle in z.
  function automatic cordic_t cordic_step(input cordic_t c, input logic [4:0] i);
    cordic_t r;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    if (c.y > 0) begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + atan_step(i);
    end else begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - atan_step(i);
    end
    return r;
  endfunction

  // One digit of the restoring square root, two radicand bits a step.
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t r;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    rem2  = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    r.rad = {s.rad[RAD_W-3:0], 2'b00};
    return r;
  endfunction

endpackage

// File: rtl/core/aoa_tdoa_measurement_predictor.sv
// Top level of the bearing and delay-difference measurement predictor.
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ------------------------------------
//  in        sink       in_valid / in_ready    position, offsets, drifts, biases
//  out       source     out_valid / out_ready  slot_index, predicted_value, is_last
//  apb       slave      psel/penable/pready    five registers at 4*index
//
// Each particle item runs through a 15-stage pipeline (difference, prescale, square,
// sum, eight stages of root digits and rotations, distance, scale product, final sums).
// A result buffer then sends the item's results one per cycle while out_ready is high;
// a new particle enters only as the last result is taken, or when none is pending.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits and the result buffer; registers take their reset values.
module aoa_tdoa_measurement_predictor (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] delay_offset_12,
  input  logic signed [31:0] delay_offset_13,
  input  logic signed [31:0] delay_offset_23,
  input  logic signed [31:0] delay_drift_12,
  input  logic signed [31:0] delay_drift_13,
  input  logic signed [31:0] delay_drift_23,
  input  logic signed [31:0] angle_bias_1,
  input  logic signed [31:0] angle_bias_2,
  input  logic signed [31:0] angle_bias_3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         slot_index,
  output logic signed [31:0] predicted_value,
  output logic               is_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

`include "aoa_tdoa_measurement_predictor_defines.svh"

  localparam int NSTG = 7 + aoatp_pkg::CORE_STAGES;
  localparam int NC   = aoatp_pkg::CORE_STAGES;

  // Configuration registers.
  logic [5:0]         angle_select;
  logic [5:0]         pair_select;
  logic [1:0]         angle_count;
  logic [15:0]        time_step;
  logic signed [31:0] range_scale;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_select <= '0;
      pair_select  <= '0;
      angle_count  <= '0;
      time_step    <= '0;
      range_scale  <= 32'sd65536;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        aoatp_pkg::REG_ANGLE_SEL: angle_select <= pwdata[5:0];
        aoatp_pkg::REG_PAIR_SEL:  pair_select  <= pwdata[5:0];
        aoatp_pkg::REG_ANGLE_CNT: angle_count  <= pwdata[1:0];
        aoatp_pkg::REG_TIME_STEP: time_step    <= pwdata[15:0];
        aoatp_pkg::REG_RANGE_SCL: range_scale  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      aoatp_pkg::REG_ANGLE_SEL: prdata = {26'd0, angle_select};
      aoatp_pkg::REG_PAIR_SEL:  prdata = {26'd0, pair_select};
      aoatp_pkg::REG_ANGLE_CNT: prdata = {30'd0, angle_count};
      aoatp_pkg::REG_TIME_STEP: prdata = {16'd0, time_step};
      aoatp_pkg::REG_RANGE_SCL: prdata = range_scale;
      default:                  prdata = '0;
    endcase
  end

  // Pipeline control: every stage moves together.
  logic [NSTG-1:0] vld;
  logic            adv;
  logic [5:0]      h_mask;
  logic [5:0]      sel_mask;
  logic            h_single;

  assign h_single = (h_mask & (h_mask - 6'd1)) == 6'd0;
  assign adv      = h_single && ((h_mask == 6'd0) || out_ready);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NSTG-2:0], in_valid};
  end

  logic signed [31:0] in_bias [3];
  logic signed [31:0] in_off  [3];
  logic signed [31:0] in_drift[3];

  assign in_bias  = '{angle_bias_1, angle_bias_2, angle_bias_3};
  assign in_off   = '{delay_offset_12, delay_offset_13, delay_offset_23};
  assign in_drift = '{delay_drift_12, delay_drift_13, delay_drift_23};

  // Stage 1: coordinate differences to each sensor.
  logic signed [31:0] s1_dx[3], s1_dy[3], s1_bias[3], s1_off[3], s1_drift[3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s1_dx[k]    <= aoatp_pkg::sat_word(64'(pos_x) - 64'(aoatp_pkg::sensor_x(2'(k))));
        s1_dy[k]    <= aoatp_pkg::sat_word(64'(pos_y) - 64'(aoatp_pkg::sensor_y(2'(k))));
        s1_bias[k]  <= in_bias[k];
        s1_off[k]   <= in_off[k];
        s1_drift[k] <= in_drift[k];
      end
    end
  end

  // Stage 2: prescale and magnitudes, rotation setup, drift term.
  logic [31:0]          s2_ax[3], s2_ay[3];
  logic                 s2_scl[3], s2_zero[3];
  aoatp_pkg::cordic_t   s2_cr[3];
  logic signed [31:0]   s2_dterm[3], s2_bias[3], s2_off[3];
  logic [16:0]          ts_lead;

  assign ts_lead = {1'b0, time_step} + 17'd2;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic               scl;
        logic signed [31:0] qx, qy;
        aoatp_pkg::cordic_t c;
        scl = (s1_dx[k] > aoatp_pkg::NEAR_LIMIT) || (s1_dx[k] < -aoatp_pkg::NEAR_LIMIT) ||
              (s1_dy[k] > aoatp_pkg::NEAR_LIMIT) || (s1_dy[k] < -aoatp_pkg::NEAR_LIMIT);
        qx = scl ? (s1_dx[k] >>> aoatp_pkg::PRESCALE_SHIFT) : s1_dx[k];
        qy = scl ? (s1_dy[k] >>> aoatp_pkg::PRESCALE_SHIFT) : s1_dy[k];
        // The angle is atan2(dx, dy): dy drives the x axis of the rotation.
        if (s1_dy[k] < 0) begin
          c.x = -aoatp_pkg::CORDIC_W'(s1_dy[k]);
          c.y = -aoatp_pkg::CORDIC_W'(s1_dx[k]);
          c.z = (s1_dx[k] >= 0) ? aoatp_pkg::PI_Q : -aoatp_pkg::PI_Q;
        end else begin
          c.x = aoatp_pkg::CORDIC_W'(s1_dy[k]);
          c.y = aoatp_pkg::CORDIC_W'(s1_dx[k]);
          c.z = '0;
        end
        s2_scl[k]   <= scl;
        s2_ax[k]    <= (qx < 0) ? 32'(-qx) : 32'(qx);
        s2_ay[k]    <= (qy < 0) ? 32'(-qy) : 32'(qy);
        s2_cr[k]    <= c;
        s2_zero[k]  <= (s1_dx[k] == 32'sd0) && (s1_dy[k] == 32'sd0);
        s2_dterm[k] <= aoatp_pkg::sat_word(64'(s1_drift[k]) * 64'($signed({1'b0, ts_lead})));
        s2_bias[k]  <= s1_bias[k];
        s2_off[k]   <= s1_off[k];
      end
    end
  end

  // Stage 3: squares.
  logic [63:0]          s3_sqx[3], s3_sqy[3];
  logic                 s3_scl[3], s3_zero[3];
  aoatp_pkg::cordic_t   s3_cr[3];
  logic signed [31:0]   s3_dterm[3], s3_bias[3], s3_off[3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s3_sqx[k]   <= 64'(s2_ax[k]) * 64'(s2_ax[k]);
        s3_sqy[k]   <= 64'(s2_ay[k]) * 64'(s2_ay[k]);
        s3_scl[k]   <= s2_scl[k];
        s3_zero[k]  <= s2_zero[k];
        s3_cr[k]    <= s2_cr[k];
        s3_dterm[k] <= s2_dterm[k];
        s3_bias[k]  <= s2_bias[k];
        s3_off[k]   <= s2_off[k];
      end
    end
  end

  // Stage 4 is core entry 0: saturated sum of squares becomes the root radicand.
  aoatp_pkg::sqrt_t   c_sq  [NC+1][3];
  aoatp_pkg::cordic_t c_cr  [NC+1][3];
  logic               c_scl [NC+1][3];
  logic               c_zero[NC+1][3];
  logic signed [31:0] c_dterm[NC+1][3];
  logic signed [31:0] c_bias[NC+1][3];
  logic signed [31:0] c_off [NC+1][3];

  aoatp_pkg::sqrt_t   c_sq_next[NC+1][3];
  aoatp_pkg::cordic_t c_cr_next[NC+1][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic [63:0] sum;
        logic [30:0] sum_sat;
        sum     = (s3_sqx[k] >> aoatp_pkg::FRAC_BITS) + (s3_sqy[k] >> aoatp_pkg::FRAC_BITS);
        sum_sat = (sum > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : sum[30:0];
        c_sq[0][k].rad  <= {1'b0, sum_sat, 16'd0};
        c_sq[0][k].rem  <= '0;
        c_sq[0][k].root <= '0;
        c_cr[0][k]      <= s3_cr[k];
        c_scl[0][k]     <= s3_scl[k];
        c_zero[0][k]    <= s3_zero[k];
        c_dterm[0][k]   <= s3_dterm[k];
        c_bias[0][k]    <= s3_bias[k];
        c_off[0][k]     <= s3_off[k];
      end
    end
  end

  // Core stages: three root digits and up to three rotations each.
  always_comb begin
    for (int c = 0; c <= NC; c++) begin
      for (int k = 0; k < 3; k++) begin
        c_sq_next[c][k] = c_sq[c][k];
        c_cr_next[c][k] = c_cr[c][k];
        for (int j = 0; j < aoatp_pkg::STEPS_PER_STAGE; j++) begin
          c_sq_next[c][k] = aoatp_pkg::sqrt_step(c_sq_next[c][k]);
          if (c * aoatp_pkg::STEPS_PER_STAGE + j < aoatp_pkg::CORDIC_STEPS) begin
            c_cr_next[c][k] = aoatp_pkg::cordic_step(c_cr_next[c][k],
                                5'(c * aoatp_pkg::STEPS_PER_STAGE + j));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 1; c <= NC; c++) begin
        for (int k = 0; k < 3; k++) begin
          c_sq[c][k]    <= c_sq_next[c-1][k];
          c_cr[c][k]    <= c_cr_next[c-1][k];
          c_scl[c][k]   <= c_scl[c-1][k];
          c_zero[c][k]  <= c_zero[c-1][k];
          c_dterm[c][k] <= c_dterm[c-1][k];
          c_bias[c][k]  <= c_bias[c-1][k];
          c_off[c][k]   <= c_off[c-1][k];
        end
      end
    end
  end

  // Final stage 1: distances and biased angles.
  logic signed [31:0] f1_dist[3], f1_ang[3], f1_off[3], f1_dterm[3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        f1_dist[k] <= c_scl[NC][k] ? {1'b0, c_sq[NC][k].root, 7'd0}
                                   : {8'd0, c_sq[NC][k].root};
        f1_ang[k]  <= c_zero[NC][k] ? c_bias[NC][k]
                    : aoatp_pkg::sat_word(64'(c_cr[NC][k].z) + 64'(c_bias[NC][k]));
        f1_off[k]   <= c_off[NC][k];
        f1_dterm[k] <= c_dterm[NC][k];
      end
    end
  end

  // Final stage 2: distance differences times the range scale.
  logic signed [63:0] f2_prod[3];
  logic signed [31:0] f2_ang[3], f2_off[3], f2_dterm[3];
  logic signed [31:0] pair_diff[3];

  assign pair_diff[0] = f1_dist[0] - f1_dist[1];
  assign pair_diff[1] = f1_dist[0] - f1_dist[2];
  assign pair_diff[2] = f1_dist[1] - f1_dist[2];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        f2_prod[k]  <= 64'(pair_diff[k]) * 64'(range_scale);
        f2_ang[k]   <= f1_ang[k];
        f2_off[k]   <= f1_off[k];
        f2_dterm[k] <= f1_dterm[k];
      end
    end
  end

  // Final stage 3: offset and drift sums.
  logic signed [31:0] f3_pv[3], f3_ang[3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [31:0] t1, t2;
        t1 = aoatp_pkg::sat_word(f2_prod[k] >>> aoatp_pkg::FRAC_BITS);
        t2 = aoatp_pkg::sat_word(64'(t1) + 64'(f2_off[k]));
        f3_pv[k]  <= aoatp_pkg::sat_word(64'(t2) + 64'(f2_dterm[k]));
        f3_ang[k] <= f2_ang[k];
      end
    end
  end

  // Result buffer: one bit for each pending result, angle slots first.
  logic signed [31:0] h_ang[3], h_pv[3];
  logic [2:0]         pair_base[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sel_mask[i]     = angle_select[2*i +: 2] != 2'd0;
      sel_mask[3 + i] = pair_select[2*i +: 2] != 2'd0;
    end
  end

  assign pair_base[0] = {1'b0, angle_count};
  assign pair_base[1] = pair_base[0] + {2'd0, sel_mask[3]};
  assign pair_base[2] = pair_base[1] + {2'd0, sel_mask[4]};

  always_ff @(posedge clk) begin
    if (rst) begin
      h_mask <= '0;
    end else if (adv) begin
      h_mask <= vld[NSTG-1] ? sel_mask : 6'd0;
    end else if (out_ready && (h_mask != 6'd0)) begin
      h_mask <= h_mask & (h_mask - 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_ang <= f3_ang;
      h_pv  <= f3_pv;
    end
  end

  always_comb begin
    logic [2:0] pos;
    logic [1:0] sel;
    pos = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (h_mask[i]) pos = 3'(i);
    end
    if (pos < 3'd3) begin
      sel        = angle_select[2*pos +: 2];
      slot_index = pos;
      case (sel)
        2'd1:    predicted_value = h_ang[0];
        2'd2:    predicted_value = h_ang[1];
        2'd3:    predicted_value = h_ang[2];
        default: predicted_value = '0;
      endcase
    end else begin
      sel        = pair_select[2*(pos - 3'd3) +: 2];
      slot_index = pair_base[2'(pos - 3'd3)];
      case (sel)
        2'd1:    predicted_value = h_pv[0];
        2'd2:    predicted_value = h_pv[1];
        2'd3:    predicted_value = h_pv[2];
        default: predicted_value = '0;
      endcase
    end
  end

  assign out_valid = h_mask != 6'd0;
  assign is_last   = h_single;

  `AOATP_ASSERT_ALWAYS(a_mask_selected, (h_mask & ~sel_mask) == 6'd0, "pending result not selected")
  `AOATP_ASSERT_NEXT(a_one_per_accept, out_valid && out_ready && !is_last, $countones(h_mask) == $countones($past(h_mask)) - 1, "result buffer lost or kept a result")
  `AOATP_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld), "pipeline moved during a stall")
  `AOATP_ASSERT_IMPL(a_busy_blocks_input, out_valid && !(out_ready && is_last), !in_ready, "input taken while results pending")

endmodule
